[rtl/afp_pkg.sv]
// Package for the FTP PORT address parser.
// Holds the input and result item types used across the modules; no dependencies.
`default_nettype none

package afp_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] addr_byte0;
        logic [7:0] addr_byte1;
        logic [7:0] addr_byte2;
        logic [7:0] addr_byte3;
        logic [7:0] port_high;
        logic [7:0] port_low;
        logic       ok;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/afp_in_reg.sv]
// Input register of the FTP PORT address parser.
// Holds one accepted item until the core takes it; uses afp_pkg.
`default_nettype none

module afp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  afp_pkg::t_in_item i_data,
    input  logic              i_take,
    output logic              o_valid,
    output afp_pkg::t_in_item o_data
);
    import afp_pkg::*;

    logic     r_valid;
    t_in_item r_data;
    logic     n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/afp_core.sv]
// Lexer and token checker of the FTP PORT address parser; uses afp_pkg.
// Takes one byte per cycle; a string end waits for a free slot, then loads its result item.
`default_nettype none

module afp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  afp_pkg::t_in_item  i_item,
    input  logic               i_slot_free,
    output logic               o_take,
    output logic               o_load,
    output afp_pkg::t_out_item o_result
);
    import afp_pkg::*;

    localparam logic [7:0] C_CH_NUL     = 8'h00;
    localparam logic [7:0] C_CH_TAB     = 8'h09;
    localparam logic [7:0] C_CH_CR      = 8'h0D;
    localparam logic [7:0] C_CH_NEWLINE = 8'h0A;
    localparam logic [7:0] C_CH_SPACE   = 8'h20;
    localparam logic [7:0] C_CH_BANG    = 8'h21;
    localparam logic [7:0] C_CH_QUOTE   = 8'h22;
    localparam logic [7:0] C_CH_AMP     = 8'h26;
    localparam logic [7:0] C_CH_APOS    = 8'h27;
    localparam logic [7:0] C_CH_LPAREN  = 8'h28;
    localparam logic [7:0] C_CH_RPAREN  = 8'h29;
    localparam logic [7:0] C_CH_STAR    = 8'h2A;
    localparam logic [7:0] C_CH_PLUS    = 8'h2B;
    localparam logic [7:0] C_CH_COMMA   = 8'h2C;
    localparam logic [7:0] C_CH_MINUS   = 8'h2D;
    localparam logic [7:0] C_CH_SLASH   = 8'h2F;
    localparam logic [7:0] C_CH_ZERO    = 8'h30;
    localparam logic [7:0] C_CH_NINE    = 8'h39;
    localparam logic [7:0] C_CH_COLON   = 8'h3A;
    localparam logic [7:0] C_CH_SEMI    = 8'h3B;
    localparam logic [7:0] C_CH_LT      = 8'h3C;
    localparam logic [7:0] C_CH_EQ      = 8'h3D;
    localparam logic [7:0] C_CH_GT      = 8'h3E;
    localparam logic [7:0] C_CH_LBRACE  = 8'h7B;
    localparam logic [7:0] C_CH_PIPE    = 8'h7C;
    localparam logic [7:0] C_CH_RBRACE  = 8'h7D;

    localparam logic [3:0] C_TOKEN_COUNT = 4'd11;
    localparam logic [3:0] C_OK_POS      = 4'd10;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_LINE,
        MODE_BLOCK,
        MODE_QUOTE,
        MODE_WORD
    } t_mode;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_mode           mode;
        logic            pend_slash;
        logic            pend_star;
        logic [7:0]      first_char;
        logic [7:0]      acc;
        t_phase          phase;
        logic            neg;
        logic [3:0]      tok_pos;
        logic [5:0][7:0] bytes;
        logic            failed;
        logic            done;
    } t_state;

    function automatic t_state f_cleared();
        t_state r;
        r            = '0;
        r.mode       = MODE_SKIP;
        r.phase      = PH_SIGN;
        return r;
    endfunction

    function automatic logic f_is_punct(input logic [7:0] c);
        return c inside {C_CH_COMMA, C_CH_LBRACE, C_CH_RBRACE, C_CH_RPAREN, C_CH_LPAREN,
                         C_CH_APOS, C_CH_COLON, C_CH_SEMI, C_CH_EQ, C_CH_BANG, C_CH_GT,
                         C_CH_LT, C_CH_AMP, C_CH_PIPE, C_CH_PLUS};
    endfunction

    function automatic t_state f_begin(input t_state s);
        t_state r;
        r            = s;
        r.first_char = C_CH_NUL;
        r.acc        = 8'd0;
        r.phase      = PH_SIGN;
        r.neg        = 1'b0;
        return r;
    endfunction

    function automatic t_state f_feed(input t_state s, input logic [7:0] c);
        t_state     r;
        logic       digit;
        logic [7:0] dval;
        r     = s;
        digit = (c >= C_CH_ZERO) && (c <= C_CH_NINE);
        dval  = c - C_CH_ZERO;
        if (r.first_char == C_CH_NUL) begin
            r.first_char = c;
        end
        case (r.phase)
            PH_SIGN: begin
                if ((c inside {[C_CH_TAB:C_CH_CR]}) || (c == C_CH_SPACE)) begin
                    r.phase = PH_SIGN;
                end else if (c == C_CH_PLUS) begin
                    r.phase = PH_DIGITS;
                end else if (c == C_CH_MINUS) begin
                    r.neg   = 1'b1;
                    r.phase = PH_DIGITS;
                end else if (digit) begin
                    r.acc   = dval;
                    r.phase = PH_DIGITS;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    r.acc = (r.acc << 3) + (r.acc << 1) + dval;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            default: begin
                r.phase = r.phase;
            end
        endcase
        return r;
    endfunction

    function automatic t_state f_end(input t_state s);
        t_state     r;
        logic [7:0] value;
        r     = s;
        value = r.neg ? (8'd0 - r.acc) : r.acc;
        if (!r.done && (r.tok_pos < C_TOKEN_COUNT)) begin
            if (r.tok_pos[0] && (r.first_char != C_CH_COMMA)) begin
                r.failed = 1'b1;
                r.done   = 1'b1;
            end else begin
                if (!r.tok_pos[0]) begin
                    r.bytes[r.tok_pos[3:1]] = value;
                end
                r.tok_pos = r.tok_pos + 4'd1;
                if (r.tok_pos >= C_TOKEN_COUNT) begin
                    r.done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_state f_skip(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        if (c > C_CH_SPACE) begin
            if (c == C_CH_SLASH) begin
                r.pend_slash = 1'b1;
            end else if (c == C_CH_QUOTE) begin
                r      = f_begin(r);
                r.mode = MODE_QUOTE;
            end else if (f_is_punct(c)) begin
                r = f_begin(r);
                r = f_feed(r, c);
                r = f_end(r);
            end else begin
                r      = f_begin(r);
                r      = f_feed(r, c);
                r.mode = MODE_WORD;
            end
        end
        return r;
    endfunction

    function automatic t_state f_word(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        if (f_is_punct(c)) begin
            r      = f_end(r);
            r.mode = MODE_SKIP;
            r      = f_skip(r, c);
        end else if (c <= C_CH_SPACE) begin
            r      = f_end(r);
            r.mode = MODE_SKIP;
        end else begin
            r = f_feed(r, c);
        end
        return r;
    endfunction

    function automatic t_state f_byte(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        case (r.mode)
            MODE_SKIP: begin
                if (r.pend_slash) begin
                    r.pend_slash = 1'b0;
                    if (c == C_CH_SLASH) begin
                        r.mode = MODE_LINE;
                    end else if (c == C_CH_STAR) begin
                        r.mode      = MODE_BLOCK;
                        r.pend_star = 1'b0;
                    end else begin
                        r      = f_begin(r);
                        r      = f_feed(r, C_CH_SLASH);
                        r.mode = MODE_WORD;
                        r      = f_word(r, c);
                    end
                end else begin
                    r = f_skip(r, c);
                end
            end
            MODE_LINE: begin
                if (c == C_CH_NEWLINE) begin
                    r.mode = MODE_SKIP;
                end
            end
            MODE_BLOCK: begin
                if (r.pend_star && (c == C_CH_SLASH)) begin
                    r.pend_star = 1'b0;
                    r.mode      = MODE_SKIP;
                end else begin
                    r.pend_star = (c == C_CH_STAR);
                end
            end
            MODE_QUOTE: begin
                if (c == C_CH_QUOTE) begin
                    r      = f_end(r);
                    r.mode = MODE_SKIP;
                end else begin
                    r = f_feed(r, c);
                end
            end
            MODE_WORD: begin
                r = f_word(r, c);
            end
            default: begin
                r.mode = MODE_SKIP;
            end
        endcase
        return r;
    endfunction

    function automatic t_state f_finish(input t_state s);
        t_state r;
        r = s;
        if ((r.mode == MODE_SKIP) && r.pend_slash) begin
            r = f_begin(r);
            r = f_feed(r, C_CH_SLASH);
            r = f_end(r);
        end else if ((r.mode == MODE_WORD) || (r.mode == MODE_QUOTE)) begin
            r = f_end(r);
        end
        return r;
    endfunction

    t_state r_state;
    t_state n_state;
    t_state stepped;
    t_state finished;
    logic   emits;
    logic   ok;

    always_comb begin
        stepped = r_state;
        if (i_item.char_in != C_CH_NUL) begin
            stepped = f_byte(r_state, i_item.char_in);
        end
        finished = f_finish(stepped);
        emits    = (i_item.char_in == C_CH_NUL) || i_item.end_of_string;
        ok       = !finished.failed && (finished.tok_pos >= C_OK_POS);
        o_take   = i_valid && (!emits || i_slot_free);
        o_load   = o_take && emits;
        n_state  = emits ? f_cleared() : stepped;

        o_result.addr_byte0 = ok ? finished.bytes[0] : 8'd0;
        o_result.addr_byte1 = ok ? finished.bytes[1] : 8'd0;
        o_result.addr_byte2 = ok ? finished.bytes[2] : 8'd0;
        o_result.addr_byte3 = ok ? finished.bytes[3] : 8'd0;
        o_result.port_high  = ok ? finished.bytes[4] : 8'd0;
        o_result.port_low   = ok ? finished.bytes[5] : 8'd0;
        o_result.ok         = ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_cleared();
        end else if (o_take) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_cleared_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_state == f_cleared()))
        else $error("parser state not cleared after a result item");

    a_done_at_last_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.tok_pos == C_TOKEN_COUNT) |-> r_state.done)
        else $error("token position at limit without done flag");

    a_failed_implies_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.failed |-> r_state.done)
        else $error("failed flag set without done flag");
`endif

endmodule

`default_nettype wire

[rtl/afp_out_reg.sv]
// Result register of the FTP PORT address parser.
// Holds one result item until the downstream side takes it; uses afp_pkg.
`default_nettype none

module afp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  afp_pkg::t_out_item i_data,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output afp_pkg::t_out_item o_data
);
    import afp_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/ftp_port_address_parser_unit.sv]
// A string's last item is registered in afp_in_reg, and its result item in afp_out_reg.
// Throughput: one item per cycle, set by afp_core; a string end waits for a free slot.
// Results wait in the output register while the next items are accepted.
// Reset is synchronous and active low; it clears the lexer state and both valid flags.
// Top level of the FTP PORT address parser; uses afp_pkg, afp_in_reg, afp_core, afp_out_reg.
`default_nettype none

module ftp_port_address_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  afp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output afp_pkg::t_out_item o_out_data
);
    import afp_pkg::*;

    logic      w_item_valid;
    t_in_item  w_item;
    logic      w_take;
    logic      w_load;
    logic      w_slot_free;
    t_out_item w_result;

    afp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_data  (w_item)
    );

    afp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_item_valid),
        .i_item      (w_item),
        .i_slot_free (w_slot_free),
        .o_take      (w_take),
        .o_load      (w_load),
        .o_result    (w_result)
    );

    afp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_result),
        .o_free  (w_slot_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && o_out_valid) |-> i_out_ready)
        else $error("result item overwritten before it was taken");

    a_failed_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |-> ((o_out_data.addr_byte0 == 8'd0) &&
            (o_out_data.addr_byte1 == 8'd0) && (o_out_data.addr_byte2 == 8'd0) &&
            (o_out_data.addr_byte3 == 8'd0) && (o_out_data.port_high == 8'd0) &&
            (o_out_data.port_low == 8'd0)))
        else $error("failed result item carries nonzero bytes");
`endif

endmodule

`default_nettype wire

[sim/ftp_port_address_parser_unit_tb.sv]
// Self-checking testbench for ftp_port_address_parser_unit with a predictor of host and port.
// Feeds hand-picked and random PORT argument strings one byte per item under random valid/ready idling.
// Depends on afp_pkg and the parser RTL only.

typedef enum logic [2:0] {
    SCAN_GAP,
    SCAN_LINE_NOTE,
    SCAN_BLOCK_NOTE,
    SCAN_QUOTED,
    SCAN_WORD
} scan_mode_e;

typedef enum logic [1:0] {
    NUM_LEAD,
    NUM_DIGITS,
    NUM_STOPPED
} num_phase_e;

localparam logic [7:0] CH_NL    = 8'h0A;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_QUOTE = 8'h22;
localparam logic [7:0] CH_STAR  = 8'h2A;
localparam logic [7:0] CH_PLUS  = 8'h2B;
localparam logic [7:0] CH_COMMA = 8'h2C;
localparam logic [7:0] CH_MINUS = 8'h2D;
localparam logic [7:0] CH_SLASH = 8'h2F;
localparam logic [7:0] CH_ZERO  = 8'h30;
localparam logic [7:0] CH_NINE  = 8'h39;
localparam int unsigned FIELD_TOKENS = 11;
localparam int unsigned REPORT_LIMIT = 10;

class host_port_predictor;
    scan_mode_e  mode;
    bit          slash_held;
    bit          star_held;
    int unsigned token_idx;
    bit [7:0]    value_acc;
    num_phase_e  phase;
    bit          minus_seen;
    bit [7:0]    lead_char;
    bit [7:0]    numbers [6];
    bit          failed;
    bit          finished;

    afp_pkg::t_out_item expected_hosts[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned ok_results;
    int unsigned strings_seen;

    function void start_token();
        lead_char  = '0;
        value_acc  = '0;
        phase      = NUM_LEAD;
        minus_seen = 1'b0;
    endfunction

    function void clear_parse();
        mode       = SCAN_GAP;
        slash_held = 1'b0;
        star_held  = 1'b0;
        token_idx  = 0;
        start_token();
        foreach (numbers[j]) numbers[j] = '0;
        failed     = 1'b0;
        finished   = 1'b0;
    endfunction

    function bit is_separator(bit [7:0] c);
        case (c)
            ",", "{", "}", "(", ")", "'", ":", ";", "=", "!", ">", "<", "&", "|", "+": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void feed_token(bit [7:0] c);
        bit digit;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        if (lead_char == 0) lead_char = c;
        case (phase)
            NUM_LEAD: begin
                if (!((c >= 8'd9 && c <= 8'd13) || c == CH_SPACE)) begin
                    if (c == CH_PLUS) begin
                        phase = NUM_DIGITS;
                    end else if (c == CH_MINUS) begin
                        minus_seen = 1'b1;
                        phase = NUM_DIGITS;
                    end else if (digit) begin
                        value_acc = c - CH_ZERO;
                        phase = NUM_DIGITS;
                    end else begin
                        phase = NUM_STOPPED;
                    end
                end
            end
            NUM_DIGITS: begin
                if (digit) value_acc = value_acc * 8'd10 + (c - CH_ZERO);
                else phase = NUM_STOPPED;
            end
            default: begin
            end
        endcase
    endfunction

    function void close_token();
        if (finished || token_idx >= FIELD_TOKENS) return;
        if (token_idx % 2 == 1) begin
            if (lead_char != CH_COMMA) begin
                failed = 1'b1;
                finished = 1'b1;
                return;
            end
        end else begin
            numbers[(token_idx / 2) % 6] = minus_seen ? 8'd0 - value_acc : value_acc;
        end
        token_idx++;
        if (token_idx >= FIELD_TOKENS) finished = 1'b1;
    endfunction

    function void gap_byte(bit [7:0] c);
        if (c <= CH_SPACE) return;
        if (c == CH_SLASH) begin
            slash_held = 1'b1;
        end else if (c == CH_QUOTE) begin
            start_token();
            mode = SCAN_QUOTED;
        end else if (is_separator(c)) begin
            start_token();
            feed_token(c);
            close_token();
        end else begin
            start_token();
            feed_token(c);
            mode = SCAN_WORD;
        end
    endfunction

    function void word_byte(bit [7:0] c);
        if (is_separator(c)) begin
            close_token();
            mode = SCAN_GAP;
            gap_byte(c);
        end else if (c <= CH_SPACE) begin
            close_token();
            mode = SCAN_GAP;
        end else begin
            feed_token(c);
        end
    endfunction

    function void step_byte(bit [7:0] c);
        case (mode)
            SCAN_GAP: begin
                if (slash_held) begin
                    slash_held = 1'b0;
                    if (c == CH_SLASH) begin
                        mode = SCAN_LINE_NOTE;
                    end else if (c == CH_STAR) begin
                        mode = SCAN_BLOCK_NOTE;
                        star_held = 1'b0;
                    end else begin
                        start_token();
                        feed_token(CH_SLASH);
                        mode = SCAN_WORD;
                        word_byte(c);
                    end
                end else begin
                    gap_byte(c);
                end
            end
            SCAN_LINE_NOTE: begin
                if (c == CH_NL) mode = SCAN_GAP;
            end
            SCAN_BLOCK_NOTE: begin
                if (star_held && c == CH_SLASH) begin
                    star_held = 1'b0;
                    mode = SCAN_GAP;
                end else begin
                    star_held = (c == CH_STAR);
                end
            end
            SCAN_QUOTED: begin
                if (c == CH_QUOTE) begin
                    close_token();
                    mode = SCAN_GAP;
                end else begin
                    feed_token(c);
                end
            end
            default: word_byte(c);
        endcase
    endfunction

    // Called for every accepted input item; queues a result when the string ends.
    function void take_byte(afp_pkg::t_in_item it);
        bit [7:0] c;
        bit ok;
        afp_pkg::t_out_item host;
        c = it.char_in;
        if (c != 0) step_byte(c);
        if (c != 0 && !it.end_of_string) return;
        if (mode == SCAN_GAP && slash_held) begin
            start_token();
            feed_token(CH_SLASH);
            close_token();
        end else if (mode == SCAN_WORD || mode == SCAN_QUOTED) begin
            close_token();
        end
        ok = !failed && token_idx >= FIELD_TOKENS - 1;
        host.addr_byte0 = ok ? numbers[0] : 8'd0;
        host.addr_byte1 = ok ? numbers[1] : 8'd0;
        host.addr_byte2 = ok ? numbers[2] : 8'd0;
        host.addr_byte3 = ok ? numbers[3] : 8'd0;
        host.port_high  = ok ? numbers[4] : 8'd0;
        host.port_low   = ok ? numbers[5] : 8'd0;
        host.ok         = ok;
        expected_hosts.push_back(host);
        strings_seen++;
        clear_parse();
    endfunction

    function void compare_field(string label, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                         label, results_seen, want, got);
        end
    endfunction

    function void check_host_port(afp_pkg::t_out_item got);
        afp_pkg::t_out_item want;
        if (expected_hosts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Unexpected result item %p with no string pending", got);
            return;
        end
        want = expected_hosts.pop_front();
        results_seen++;
        if (got.ok === 1'b1) ok_results++;
        compare_field("addr_byte0", want.addr_byte0, got.addr_byte0);
        compare_field("addr_byte1", want.addr_byte1, got.addr_byte1);
        compare_field("addr_byte2", want.addr_byte2, got.addr_byte2);
        compare_field("addr_byte3", want.addr_byte3, got.addr_byte3);
        compare_field("port_high", want.port_high, got.port_high);
        compare_field("port_low", want.port_low, got.port_low);
        compare_field("ok", want.ok, got.ok);
    endfunction

    function int unsigned pending();
        return expected_hosts.size();
    endfunction
endclass

module ftp_port_address_parser_unit_tb;
    import afp_pkg::*;

    localparam int unsigned BYTE_TARGET = 1200;
    localparam int RUN_LIMIT = 2_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    host_port_predictor host_port;
    logic [7:0]  arg_bytes[$];
    int unsigned burst_left;
    int unsigned items_sent = 0;

    ftp_port_address_parser_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned new_burst();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eos);
        t_in_item it;
        it.char_in = c;
        it.end_of_string = eos;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        host_port.take_byte(it);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = new_burst();
        end
    endtask

    task automatic send_string(input bit term_on_last, input bit zero_eos);
        foreach (arg_bytes[k]) send_item(arg_bytes[k], term_on_last && k == arg_bytes.size() - 1);
        if (!term_on_last || arg_bytes.size() == 0) send_item(8'h00, zero_eos);
    endtask

    task automatic send_text(input string s);
        arg_bytes.delete();
        for (int k = 0; k < s.len(); k++) arg_bytes.push_back(s[k]);
        send_string(1'b1, 1'b0);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (host_port.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rough_byte();
        case ($urandom_range(0, 11))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_QUOTE;
            3: return CH_COMMA;
            4: return CH_NL;
            5: return CH_SPACE;
            6: return CH_MINUS;
            7: return CH_PLUS;
            8: return CH_ZERO + 8'($urandom_range(0, 9));
            9: return ";";
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void add_digits(input int unsigned n);
        repeat (n) arg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_filler();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            3, 4: repeat ($urandom_range(1, 3)) arg_bytes.push_back(8'($urandom_range(1, 32)));
            5: begin
                arg_bytes.push_back(CH_SPACE);
                arg_bytes.push_back(CH_SLASH);
                arg_bytes.push_back(CH_STAR);
                repeat ($urandom_range(0, 6)) arg_bytes.push_back(8'($urandom_range(1, 255)));
                arg_bytes.push_back(CH_STAR);
                arg_bytes.push_back(CH_SLASH);
            end
            6: begin
                arg_bytes.push_back(CH_SPACE);
                arg_bytes.push_back(CH_SLASH);
                arg_bytes.push_back(CH_SLASH);
                repeat ($urandom_range(0, 6)) begin
                    b = 8'($urandom_range(1, 254));
                    if (b >= CH_NL) b++;
                    arg_bytes.push_back(b);
                end
                arg_bytes.push_back(CH_NL);
            end
            7: arg_bytes.push_back(CH_SPACE);
            default: begin
            end
        endcase
    endfunction

    function automatic void add_number();
        int unsigned lead;
        case ($urandom_range(0, 5))
            3: begin
                arg_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 2)) begin
                    lead = $urandom_range(9, 14);
                    arg_bytes.push_back(lead == 14 ? CH_SPACE : 8'(lead));
                end
                case ($urandom_range(0, 3))
                    0: arg_bytes.push_back(CH_PLUS);
                    1: arg_bytes.push_back(CH_MINUS);
                    default: begin
                    end
                endcase
                add_digits($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) arg_bytes.push_back(8'($urandom_range(33, 255)));
                arg_bytes.push_back(CH_QUOTE);
            end
            4: begin
                add_digits($urandom_range(1, 3));
                arg_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(97, 122))
                                                               : 8'($urandom_range(128, 255)));
            end
            5: add_digits($urandom_range(3, 5));
            default: begin
                if ($urandom_range(0, 3) == 0) arg_bytes.push_back(CH_MINUS);
                add_digits($urandom_range(1, 3));
            end
        endcase
    endfunction

    // Six numbers separated by commas, sometimes a seventh; a broken string drops or corrupts
    // tokens and may leave a comment, a quote or a slash open at the end.
    function automatic void build_port_string(input bit broken);
        arg_bytes.delete();
        for (int k = 0; k < 6; k++) begin
            add_filler();
            if (!(broken && $urandom_range(0, 4) == 0)) add_number();
            if (k < 5) begin
                if (broken && $urandom_range(0, 9) == 0) break;
                add_filler();
                if (broken && $urandom_range(0, 4) == 0) arg_bytes.push_back(rough_byte());
                else arg_bytes.push_back(CH_COMMA);
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            add_filler();
            arg_bytes.push_back(CH_COMMA);
            add_number();
        end
        add_filler();
        if (broken) begin
            case ($urandom_range(0, 3))
                0: arg_bytes.push_back(CH_SLASH);
                1: begin
                    arg_bytes.push_back(CH_SLASH);
                    arg_bytes.push_back(CH_STAR);
                    repeat ($urandom_range(0, 3)) arg_bytes.push_back(8'($urandom_range(1, 255)));
                end
                2: begin
                    arg_bytes.push_back(CH_QUOTE);
                    add_digits($urandom_range(0, 3));
                end
                default: begin
                end
            endcase
        end
    endfunction

    function automatic void build_noise();
        arg_bytes.delete();
        repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(0, 29) == 0) arg_bytes.push_back(8'h00);
            else arg_bytes.push_back(rough_byte());
        end
    endfunction

    initial begin
        wait (rst_n === 1'b1);
        forever begin
            int unsigned pattern;
            int unsigned cycle;
            pattern = $urandom_range(0, 3);
            cycle = 0;
            repeat ($urandom_range(20, 200)) begin
                @(posedge clk);
                case (pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= (cycle % 5 != 0);
                endcase
                cycle++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) host_port.check_host_port(out_item);
    end

    initial begin
        int unsigned pick;
        int unsigned failures;
        host_port = new();
        host_port.clear_parse();
        burst_left = new_burst();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(8'h00, 1'b0);
        send_text("/");
        send_text("\" 7");
        send_text("1;");
        send_text("/*");
        send_item(8'hFF, 1'b1);
        send_text("-1,2,300,4,5,9,");
        pause_until_drained();

        while (items_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) build_port_string(1'b0);
            else if (pick < 17) build_port_string(1'b1);
            else build_noise();
            send_string(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 24) == 0) pause_until_drained();
        end

        in_valid <= 1'b0;
        while (host_port.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        failures = host_port.mismatches + host_port.pending();
        $display("Sent %0d bytes forming %0d strings; checked %0d result items, %0d with ok set.",
                 items_sent, host_port.strings_seen, host_port.results_seen,
                 host_port.ok_results);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found.", failures);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("Run timed out after %0d bytes sent.", items_sent);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

[sim.f]
rtl/afp_pkg.sv
rtl/afp_in_reg.sv
rtl/afp_core.sv
rtl/afp_out_reg.sv
rtl/ftp_port_address_parser_unit.sv
sim/ftp_port_address_parser_unit_tb.sv
